// File: rtl/kbu_pkg.sv
// kbu_pkg: shared types, codes and translation roms for the keyboard usart interface
// depends on nothing; imported by the top level and its testbench
`timescale 1ns / 1ps
package kbu_pkg;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] write_value;
    logic [7:0] scan_code;
    logic       scan_extended;
    logic       key_pressed;
  } kbu_in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_level;
  } kbu_out_t;

  typedef enum logic [2:0] {
    MODE_KEY    = 3'd0,
    MODE_DWRITE = 3'd1,
    MODE_DREAD  = 3'd2,
    MODE_CWRITE = 3'd3,
    MODE_SREAD  = 3'd4,
    MODE_TICK   = 3'd5
  } kbu_mode_e;

  typedef enum logic [1:0] {
    PH_MODE  = 2'd0,
    PH_SYNC1 = 2'd1,
    PH_SYNC2 = 2'd2,
    PH_RUN   = 2'd3
  } kbu_phase_e;

  localparam logic [7:0] ST_TXRDY  = 8'h01;
  localparam logic [7:0] ST_RXRDY  = 8'h02;
  localparam logic [7:0] ST_TXEMP  = 8'h04;
  localparam logic [7:0] ST_OVRUN  = 8'h10;
  localparam logic [7:0] ST_ERRS   = 8'h38;
  localparam logic [7:0] ST_RESET  = 8'h05;

  localparam logic [7:0] BYTE_ACK  = 8'hfa;
  localparam logic [7:0] BYTE_NAK  = 8'hfc;
  localparam logic [7:0] BYTE_A0   = 8'ha0;
  localparam logic [7:0] BYTE_85   = 8'h85;
  localparam logic [7:0] BYTE_FB   = 8'hfb;
  localparam logic [7:0] BYTE_80   = 8'h80;

  localparam logic [7:0] CMD_95    = 8'h95;
  localparam logic [7:0] CMD_9C    = 8'h9c;
  localparam logic [7:0] CMD_96    = 8'h96;
  localparam logic [7:0] CMD_99    = 8'h99;
  localparam logic [7:0] CMD_9D    = 8'h9d;
  localparam logic [7:0] CMD_9F    = 8'h9f;
  localparam logic [7:0] LED_QUERY = 8'h60;
  localparam logic [7:0] LED_RPT   = 8'h70;

  localparam logic [6:0] KEY_CAPS  = 7'h71;
  localparam logic [6:0] KEY_KANA  = 7'h72;
  localparam logic [7:0] KEY_NONE  = 8'hff;

  localparam logic [7:0] PLAIN_ROM [128] = '{
    8'hff, 8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06,
    8'h07, 8'h08, 8'h09, 8'h0a, 8'h0b, 8'h0c, 8'h0e, 8'h0f,
    8'h10, 8'h11, 8'h12, 8'h13, 8'h14, 8'h15, 8'h16, 8'h17,
    8'h18, 8'h19, 8'h1a, 8'h1b, 8'h1c, 8'h74, 8'h1d, 8'h1e,
    8'h1f, 8'h20, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26,
    8'h27, 8'hff, 8'h70, 8'h28, 8'h29, 8'h2a, 8'h2b, 8'h2c,
    8'h2d, 8'h2e, 8'h2f, 8'h30, 8'h31, 8'h32, 8'h70, 8'h45,
    8'h73, 8'h34, 8'h71, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66,
    8'h67, 8'h68, 8'h69, 8'h6a, 8'h6b, 8'hff, 8'hff, 8'h42,
    8'h43, 8'h44, 8'h40, 8'h46, 8'h47, 8'h48, 8'h49, 8'h4a,
    8'h4b, 8'h4c, 8'h4e, 8'h50, 8'hff, 8'hff, 8'hff, 8'h60,
    8'h61, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
    8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
    8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
    8'hff, 8'hff, 8'hff, 8'h33, 8'hff, 8'hff, 8'hff, 8'hff,
    8'hff, 8'h35, 8'hff, 8'h51, 8'hff, 8'h0d, 8'hff, 8'hff
  };

  localparam logic [7:0] EXT_ROM [128] = '{
    8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
    8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
    8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
    8'hff, 8'hff, 8'hff, 8'hff, 8'h1c, 8'h74, 8'hff, 8'hff,
    8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
    8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
    8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'h41, 8'hff, 8'hff,
    8'h72, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
    8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'h3e,
    8'h3a, 8'h36, 8'hff, 8'h3b, 8'hff, 8'h3c, 8'hff, 8'h3f,
    8'h3d, 8'h37, 8'h38, 8'h39, 8'hff, 8'hff, 8'hff, 8'hff,
    8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
    8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
    8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
    8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
    8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff
  };

endpackage

// File: rtl/kbu_ram.sv
// kbu_ram: generic single write, single read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
module kbu_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

// File: rtl/keyboard_usart_8251_interface.sv
// keyboard_usart_8251_interface: key event translation, byte queue, 8251 style host side
// depends on kbu_pkg and kbu_ram
//
//   channel  dir  handshake            word
//   in       in   in_valid/in_ready    kbu_in_t: mode, write, scan code, flags
//   out      out  out_valid/out_ready  kbu_out_t: read data, irq level
//   cfg      in   cfg_valid/cfg_ready  16 bit rx interval in ticks
//
// the bytes an item queues go to the ram one at a time (the queue ram has one write
// port), and a tick that pops a byte into the receive latch waits for the registered
// ram read
// reset is asynchronous; no clearing pass, the queue is tracked by pointers and count
// the result register holds a word while out_ready is low; input stalls only then,
// while queued bytes drain or while a popped byte is read from the ram
`timescale 1ns / 1ps
module keyboard_usart_8251_interface #(
  parameter int QUEUE_DEPTH = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  kbu_pkg::kbu_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output kbu_pkg::kbu_out_t out_data_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [15:0]      cfg_data_i
);
  import kbu_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  // configuration
  logic [15:0] interval_q;

  // usart state
  kbu_phase_e  phase_q, phase_d;
  logic [7:0]  status_q, status_d;
  logic        rts_q, rts_d, rxon_q, rxon_d, txon_q, txon_d;
  logic [7:0]  rxbyte_q, rxbyte_d;
  logic        irq_q, irq_d;
  logic [7:0]  lock_q, lock_d;
  logic [127:0] held_q, held_d;

  // host command collection
  logic [7:0]  cmd0_q, cmd0_d;
  logic        cmdcnt_q, cmdcnt_d;

  // queue bookkeeping
  logic [AW-1:0] head_q, head_d, tail_q, tail_d;
  logic [CW-1:0] count_q, count_d;
  logic          armed_q, armed_d;
  logic [15:0]   cdown_q, cdown_d;

  // bytes waiting for the ram write port, oldest in slot 0
  logic [7:0]  pend_q [3];
  logic [7:0]  pend_d [3];
  logic [1:0]  pend_cnt_q, pend_cnt_d;
  logic        latch_q, latch_d;

  // result register
  logic        ovalid_q, ovalid_d;
  kbu_out_t    odata_q, odata_d;

  // ram port
  logic        ram_we, ram_re;
  logic [7:0]  ram_rdata;

  // per item scratch
  logic [7:0]  enq [3];
  logic [1:0]  enq_n;
  logic [7:0]  rd;
  logic [7:0]  kraw;
  logic [6:0]  k;
  logic [7:0]  c0;
  logic        in_fire;

  assign in_ready_o  = (pend_cnt_q == 2'd0) && !latch_q && (!ovalid_q || out_ready_i);
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = ovalid_q;
  assign out_data_o  = odata_q;

  kbu_ram #(.Width(8), .Depth(QUEUE_DEPTH)) u_queue (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (head_q),
    .wdata_i (pend_q[0]),
    .re_i    (ram_re),
    .raddr_i (tail_q),
    .rdata_o (ram_rdata)
  );

  // translation lookup
  assign kraw = in_data_i.scan_extended ? EXT_ROM[in_data_i.scan_code[6:0]]
                                        : PLAIN_ROM[in_data_i.scan_code[6:0]];
  assign k    = kraw[6:0];
  // first command byte: the incoming one when no command is open
  assign c0   = cmdcnt_q ? cmd0_q : in_data_i.write_value;

  always_comb begin
    phase_d    = phase_q;
    status_d   = status_q;
    rts_d      = rts_q;
    rxon_d     = rxon_q;
    txon_d     = txon_q;
    rxbyte_d   = rxbyte_q;
    irq_d      = irq_q;
    lock_d     = lock_q;
    held_d     = held_q;
    cmd0_d     = cmd0_q;
    cmdcnt_d   = cmdcnt_q;
    head_d     = head_q;
    tail_d     = tail_q;
    count_d    = count_q;
    armed_d    = armed_q;
    cdown_d    = cdown_q;
    pend_d     = pend_q;
    pend_cnt_d = pend_cnt_q;
    latch_d    = 1'b0;
    ovalid_d   = ovalid_q && !out_ready_i;
    odata_d    = odata_q;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    enq        = '{default: 8'h00};
    enq_n      = 2'd0;
    rd         = 8'h00;

    // drain one pending byte; a full queue drops it
    if (pend_cnt_q != 2'd0) begin
      if (count_q < CW'(QUEUE_DEPTH)) begin
        ram_we  = 1'b1;
        head_d  = (head_q == AW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
        count_d = count_q + 1'b1;
      end
      pend_d[0]  = pend_q[1];
      pend_d[1]  = pend_q[2];
      pend_cnt_d = pend_cnt_q - 2'd1;
    end

    // popped byte arrives from the ram
    if (latch_q) begin
      rxbyte_d = ram_rdata;
    end

    if (in_fire) begin
      unique case (in_data_i.mode)
        MODE_KEY: begin
          if (!(!in_data_i.scan_extended && in_data_i.scan_code[7]) && kraw != KEY_NONE) begin
            if (!in_data_i.key_pressed) begin
              if (held_q[k]) begin
                enq[0] = {1'b1, k};
                enq_n  = 2'd1;
              end
              held_d[k] = 1'b0;
            end else if (k == KEY_CAPS) begin
              lock_d[2] = !lock_q[2];
              enq[0]    = lock_q[2] ? 8'hf1 : 8'h71;
              enq_n     = 2'd1;
            end else if (k == KEY_KANA) begin
              lock_d[3] = !lock_q[3];
              enq[0]    = lock_q[3] ? 8'hf2 : 8'h72;
              enq_n     = 2'd1;
            end else begin
              // repeated make gets a break first
              if (held_q[k]) begin
                enq[0] = {1'b1, k};
                enq[1] = {1'b0, k};
                enq_n  = 2'd2;
              end else begin
                enq[0] = {1'b0, k};
                enq_n  = 2'd1;
              end
              held_d[k] = 1'b1;
            end
          end
        end
        MODE_DWRITE: begin
          if (status_q[0]) begin
            status_d = status_q & ~ST_TXEMP;
            enq[0]   = BYTE_ACK;
            enq_n    = 2'd1;
            cmdcnt_d = 1'b0;
            if (!cmdcnt_q) begin
              cmd0_d = in_data_i.write_value;
            end
            priority case (c0)
              CMD_95, CMD_9C: cmdcnt_d = !cmdcnt_q;
              CMD_96: begin
                enq[1] = BYTE_A0;
                enq[2] = BYTE_85;
                enq_n  = 2'd3;
              end
              CMD_99: begin
                enq[1] = BYTE_FB;
                enq_n  = 2'd2;
              end
              CMD_9D: begin
                if (cmdcnt_q) begin
                  if (in_data_i.write_value == LED_QUERY) begin
                    enq[1] = LED_RPT | (lock_q & 8'h0d);
                    enq_n  = 2'd2;
                  end else begin
                    lock_d = in_data_i.write_value;
                  end
                end else begin
                  cmdcnt_d = 1'b1;
                end
              end
              CMD_9F: begin
                enq[1] = BYTE_A0;
                enq[2] = BYTE_80;
                enq_n  = 2'd3;
              end
              default: enq[0] = BYTE_NAK;
            endcase
          end
        end
        MODE_DREAD: begin
          status_d = status_q & ~ST_RXRDY;
          irq_d    = 1'b0;
          rd       = rxbyte_q;
        end
        MODE_CWRITE: begin
          unique case (phase_q)
            PH_MODE: begin
              if (in_data_i.write_value[1:0] != 2'b00) phase_d = PH_RUN;
              else if (in_data_i.write_value[7])    phase_d = PH_SYNC2;
              else                                  phase_d = PH_SYNC1;
            end
            PH_SYNC1: phase_d = PH_SYNC2;
            PH_SYNC2: phase_d = PH_RUN;
            PH_RUN: begin
              if (in_data_i.write_value[6]) begin
                phase_d = PH_MODE;
              end else begin
                if (in_data_i.write_value[4]) status_d = status_q & ~ST_ERRS;
                rts_d  = in_data_i.write_value[5];
                rxon_d = in_data_i.write_value[2];
                txon_d = in_data_i.write_value[0];
              end
            end
            default: phase_d = PH_MODE;
          endcase
        end
        MODE_SREAD: begin
          rd = status_q;
          if (txon_q) status_d = status_q | ST_TXEMP;
        end
        MODE_TICK: begin
          if (armed_q) begin
            if (cdown_q <= 16'd1) begin
              armed_d = 1'b0;
              if (count_q != '0 && !rts_q) begin
                tail_d  = (tail_q == AW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
                count_d = count_q - 1'b1;
                if (rxon_q) begin
                  if (status_q[1]) begin
                    status_d = status_q | ST_OVRUN;
                  end else begin
                    status_d = status_q | ST_RXRDY;
                    irq_d    = 1'b1;
                    ram_re   = 1'b1;
                    latch_d  = 1'b1;
                  end
                end
                if (count_q > CW'(1)) begin
                  armed_d = 1'b1;
                  cdown_d = interval_q;
                end
              end
            end else begin
              cdown_d = cdown_q - 16'd1;
            end
          end
        end
        default: ;
      endcase

      // any enqueue arms an idle pump, even when the byte is dropped later
      if (enq_n != 2'd0) begin
        pend_d     = enq;
        pend_cnt_d = enq_n;
        if (!armed_q) begin
          armed_d = 1'b1;
          cdown_d = interval_q;
        end
      end

      ovalid_d          = 1'b1;
      odata_d.read_data = rd;
      odata_d.irq_level = irq_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= 16'd8000;
      phase_q    <= PH_MODE;
      status_q   <= ST_RESET;
      rts_q      <= 1'b1;
      rxon_q     <= 1'b0;
      txon_q     <= 1'b0;
      rxbyte_q   <= 8'hff;
      irq_q      <= 1'b0;
      lock_q     <= 8'h00;
      held_q     <= '0;
      cmdcnt_q   <= 1'b0;
      head_q     <= '0;
      tail_q     <= '0;
      count_q    <= '0;
      armed_q    <= 1'b0;
      cdown_q    <= 16'd0;
      pend_cnt_q <= 2'd0;
      latch_q    <= 1'b0;
      ovalid_q   <= 1'b0;
    end else begin
      if (cfg_valid_i) interval_q <= cfg_data_i;
      phase_q    <= phase_d;
      status_q   <= status_d;
      rts_q      <= rts_d;
      rxon_q     <= rxon_d;
      txon_q     <= txon_d;
      rxbyte_q   <= rxbyte_d;
      irq_q      <= irq_d;
      lock_q     <= lock_d;
      held_q     <= held_d;
      cmdcnt_q   <= cmdcnt_d;
      head_q     <= head_d;
      tail_q     <= tail_d;
      count_q    <= count_d;
      armed_q    <= armed_d;
      cdown_q    <= cdown_d;
      pend_cnt_q <= pend_cnt_d;
      latch_q    <= latch_d;
      ovalid_q   <= ovalid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    cmd0_q  <= cmd0_d;
    pend_q  <= pend_d;
    odata_q <= odata_d;
  end
endmodule

// File: test/tb_keyboard_usart_8251_interface.sv
// tb_keyboard_usart_8251_interface: self-checking bench for the keyboard usart interface
// drives key events, data/control port accesses and ticks; predicts every result word
// depends on kbu_pkg and the keyboard_usart_8251_interface rtl
`timescale 1ns / 1ps
module tb_keyboard_usart_8251_interface;
  import kbu_pkg::*;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_ready_o;
  kbu_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  kbu_out_t out_data_o;
  logic     cfg_valid_i = 1'b0;
  logic     cfg_ready_o;
  logic [15:0] cfg_data_i = '0;

  keyboard_usart_8251_interface #(.QUEUE_DEPTH(256)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // shadow copy of the block state
  // ---------------------------------------------------------------------------
  logic [15:0] m_interval;
  logic [7:0]  m_locks;
  logic        m_held [128];
  kbu_phase_e  m_phase;
  logic [7:0]  m_status;
  logic        m_rts, m_rxon, m_txon;
  logic [7:0]  m_latch;
  logic [7:0]  m_fifo [256];
  int          m_count, m_head, m_tail;
  logic [7:0]  m_cmd [2];
  int          m_ncmd;
  logic        m_armed;
  int          m_countdown;
  logic        m_irq;

  kbu_out_t    expected_words[$];
  int          errors = 0;

  task automatic model_reset();
    m_interval = 16'd8000;
    m_locks = '0;
    foreach (m_held[i]) m_held[i] = 1'b0;
    m_phase = PH_MODE;
    m_status = ST_RESET;
    m_rts = 1'b1; m_rxon = 1'b0; m_txon = 1'b0;
    m_latch = 8'hff;
    m_count = 0; m_head = 0; m_tail = 0;
    m_cmd[0] = '0; m_cmd[1] = '0;
    m_ncmd = 0;
    m_armed = 1'b0; m_countdown = 0; m_irq = 1'b0;
  endtask

  // every enqueue arms an idle pump, even when the byte is dropped
  task automatic push_byte(input logic [7:0] b);
    if (!m_armed) begin
      m_armed = 1'b1;
      m_countdown = m_interval;
    end
    if (m_count < 256) begin
      m_fifo[m_head] = b;
      m_head = (m_head + 1) % 256;
      m_count++;
    end
  endtask

  task automatic host_byte(input logic [7:0] v);
    m_cmd[m_ncmd & 1] = v;
    m_ncmd = (m_ncmd + 1) & 3;
    case (m_cmd[0])
      CMD_95, CMD_9C: begin
        push_byte(BYTE_ACK);
        if (m_ncmd == 2) m_ncmd = 0;
      end
      CMD_96: begin
        push_byte(BYTE_ACK); push_byte(BYTE_A0); push_byte(BYTE_85);
        m_ncmd = 0;
      end
      CMD_99: begin
        push_byte(BYTE_ACK); push_byte(BYTE_FB);
        m_ncmd = 0;
      end
      CMD_9D: begin
        push_byte(BYTE_ACK);
        if (m_ncmd == 2) begin
          if (m_cmd[1] == LED_QUERY) push_byte(LED_RPT | (m_locks & 8'h0d));
          else m_locks = v;
          m_ncmd = 0;
        end
      end
      CMD_9F: begin
        push_byte(BYTE_ACK); push_byte(BYTE_A0); push_byte(BYTE_80);
        m_ncmd = 0;
      end
      default: begin
        push_byte(BYTE_NAK);
        m_ncmd = 0;
      end
    endcase
  endtask

  task automatic key_stroke(input logic [7:0] code, input logic ext, input logic pressed);
    logic [7:0] k;
    if (ext) k = EXT_ROM[code[6:0]];
    else if (!code[7]) k = PLAIN_ROM[code[6:0]];
    else return;
    if (k == KEY_NONE) return;
    k[7] = 1'b0;
    if (!pressed) begin
      if (m_held[k[6:0]]) push_byte(k | 8'h80);
      m_held[k[6:0]] = 1'b0;
    end else if (k[6:0] == KEY_CAPS) begin
      m_locks ^= 8'h04;
      push_byte(m_locks[2] ? 8'h71 : 8'hf1);
    end else if (k[6:0] == KEY_KANA) begin
      m_locks ^= 8'h08;
      push_byte(m_locks[3] ? 8'h72 : 8'hf2);
    end else begin
      if (m_held[k[6:0]]) push_byte(k | 8'h80);
      push_byte(k);
      m_held[k[6:0]] = 1'b1;
    end
  endtask

  task automatic pump_fire();
    logic [7:0] b;
    m_armed = 1'b0;
    if (m_count == 0 || m_rts) return;
    b = m_fifo[m_tail];
    m_tail = (m_tail + 1) % 256;
    m_count--;
    if (m_rxon) begin
      if (m_status & ST_RXRDY) m_status |= ST_OVRUN;
      else begin
        m_status |= ST_RXRDY;
        m_latch = b;
        m_irq = 1'b1;
      end
    end
    if (m_count > 0) begin
      m_armed = 1'b1;
      m_countdown = m_interval;
    end
  endtask

  task automatic control_byte(input logic [7:0] v);
    case (m_phase)
      PH_MODE:  m_phase = (v[1:0] != 0) ? PH_RUN : (v[7] ? PH_SYNC2 : PH_SYNC1);
      PH_SYNC1: m_phase = PH_SYNC2;
      PH_SYNC2: m_phase = PH_RUN;
      default: begin
        if (v[6]) m_phase = PH_MODE;
        else begin
          if (v[4]) m_status &= ~ST_ERRS;
          m_rts = v[5]; m_rxon = v[2]; m_txon = v[0];
        end
      end
    endcase
  endtask

  // predicts one result word for one accepted input word
  task automatic predict_word(input kbu_in_t w);
    kbu_out_t r;
    r.read_data = '0;
    case (w.mode)
      MODE_KEY: key_stroke(w.scan_code, w.scan_extended, w.key_pressed);
      MODE_DWRITE: if (m_status & ST_TXRDY) begin
        m_status &= ~ST_TXEMP;
        host_byte(w.write_value);
      end
      MODE_DREAD: begin
        m_status &= ~ST_RXRDY;
        m_irq = 1'b0;
        r.read_data = m_latch;
      end
      MODE_CWRITE: control_byte(w.write_value);
      MODE_SREAD: begin
        r.read_data = m_status;
        if (m_txon) m_status |= ST_TXEMP;
      end
      MODE_TICK: if (m_armed) begin
        if (m_countdown <= 1) pump_fire();
        else m_countdown--;
      end
      default: ;
    endcase
    r.irq_level = m_irq;
    expected_words.push_back(r);
  endtask

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  int stall_mode = 1;  // 0 never stall, 1 random stalls

  // valid drops only ahead of a gap, so back to back words keep it high
  task automatic send_word(input kbu_in_t w);
    int g;
    g = (stall_mode != 0) ? gap_len() : 0;
    if (g != 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= w;
    do @(posedge clk_i); while (!in_ready_o);
    predict_word(w);
  endtask

  function automatic kbu_in_t make_word(input int md, input int wv, input int sc,
                                        input int ex, input int pr);
    kbu_in_t w;
    w.mode = 3'(md); w.write_value = 8'(wv); w.scan_code = 8'(sc);
    w.scan_extended = 1'(ex); w.key_pressed = 1'(pr);
    return w;
  endfunction

  task automatic write_interval(input logic [15:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    m_interval = v;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  // output side: random ready, stalls mostly short with some long ones
  initial begin
    int g;
    forever begin
      @(posedge clk_i);
      if (stall_mode != 0 && $urandom_range(0, 2) == 0) begin
        g = gap_len();
        if (g != 0) begin
          out_ready_i <= 1'b0;
          repeat (g) @(posedge clk_i);
        end
      end
      out_ready_i <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk_i) begin
    kbu_out_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word %h", $time, out_data_o);
        errors++;
      end else begin
        e = expected_words.pop_front();
        if (out_data_o.read_data !== e.read_data) begin
          $display("%0t: read_data expected %h actual %h", $time, e.read_data,
                   out_data_o.read_data);
          errors++;
        end
        if (out_data_o.irq_level !== e.irq_level) begin
          $display("%0t: irq_level expected %b actual %b", $time, e.irq_level,
                   out_data_o.irq_level);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  task automatic tick_n(input int n);
    repeat (n) send_word(make_word(MODE_TICK, $urandom, $urandom, $urandom, $urandom));
  endtask

  task automatic ctrl(input logic [7:0] v);
    send_word(make_word(MODE_CWRITE, v, $urandom, $urandom, $urandom));
  endtask

  // directed: setup sequences, every mode, rom edges, locks, commands, overrun
  task automatic test_directed();
    send_word(make_word(3'd6, 8'hff, 8'hff, 1'b1, 1'b1));
    send_word(make_word(3'd7, 8'h00, 8'h00, 1'b0, 1'b0));
    send_word(make_word(MODE_SREAD, 0, 0, 0, 0));
    ctrl(8'h00); ctrl(8'h16); ctrl(8'h16);         // two sync bytes
    ctrl(8'h40);                                    // back to mode byte
    ctrl(8'h80); ctrl(8'h16);                       // one sync byte
    ctrl(8'h40);
    ctrl(8'h4e); ctrl(8'h15);                       // async, rx on, tx on, clear errors
    send_word(make_word(MODE_KEY, 0, 8'h01, 0, 1)); // plain press
    send_word(make_word(MODE_KEY, 0, 8'h01, 0, 1)); // repeat gives break first
    send_word(make_word(MODE_KEY, 0, 8'h01, 0, 0));
    send_word(make_word(MODE_KEY, 0, 8'hff, 0, 1)); // plain high code ignored
    send_word(make_word(MODE_KEY, 0, 8'h00, 0, 1)); // unmapped
    send_word(make_word(MODE_KEY, 0, 8'hb8, 1, 1)); // extended, low bits only
    send_word(make_word(MODE_KEY, 0, 8'h3a, 0, 1)); // caps toggles
    send_word(make_word(MODE_KEY, 0, 8'h3a, 0, 1));
    send_word(make_word(MODE_KEY, 0, 8'h70, 0, 1));
    send_word(make_word(MODE_KEY, 0, 8'h38, 1, 1)); // kana
    send_word(make_word(MODE_DWRITE, CMD_9D, 0, 0, 0));
    send_word(make_word(MODE_DWRITE, LED_QUERY, 0, 0, 0));
    send_word(make_word(MODE_DWRITE, CMD_96, 0, 0, 0));
    send_word(make_word(MODE_DWRITE, 8'h00, 0, 0, 0));
    tick_n(1);                                      // interval one: fires at once
    tick_n(3);                                      // overrun
    send_word(make_word(MODE_SREAD, 0, 0, 0, 0));
    send_word(make_word(MODE_DREAD, 0, 0, 0, 0));
  endtask

  // drain the queue into the latch to restore a known empty queue
  task automatic flush_queue();
    ctrl(8'h05);
    while (m_count != 0 || m_armed) begin
      // an idle pump only rearms on an enqueue; a rejected command does that
      if (!m_armed) send_word(make_word(MODE_DWRITE, 8'h00, 0, 0, 0));
      tick_n(1);
      if (m_irq) send_word(make_word(MODE_DREAD, 0, 0, 0, 0));
    end
  endtask

  // fill past 256 bytes with rts held so the full-queue drop is exercised
  task automatic test_full_queue();
    ctrl(8'h20);
    repeat (100) send_word(make_word(MODE_DWRITE, CMD_9F, 0, 0, 0));
    tick_n(3);
    flush_queue();
  endtask

  function automatic logic [7:0] pick_ctrl();
    int p;
    p = $urandom_range(0, 19);
    if (p == 0) return 8'h40 | 8'($urandom);
    if (p < 3) return 8'($urandom);
    return {2'b00, 1'($urandom_range(0, 5) == 0), 1'($urandom), 1'b0,
            1'($urandom_range(0, 5) != 0), 1'b0, 1'($urandom)};
  endfunction

  function automatic logic [7:0] pick_cmd();
    case ($urandom_range(0, 8))
      0: return CMD_95;
      1: return CMD_9C;
      2: return CMD_96;
      3: return CMD_99;
      4, 5: return CMD_9D;
      6: return CMD_9F;
      7: return LED_QUERY;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic test_random(input int n);
    int p;
    logic [7:0] v;
    for (int i = 0; i < n; i++) begin
      // a mode byte in the wrong phase gets the setup back on track
      if (m_phase != PH_RUN && $urandom_range(0, 3) != 0) begin
        ctrl($urandom_range(0, 1) ? 8'h4e : 8'($urandom));
        continue;
      end
      p = $urandom_range(0, 99);
      if (p < 30) begin
        v = 8'($urandom);
        if ($urandom_range(0, 9) == 0) v[7] = 1'b1;
        else v[7] = 1'b0;
        send_word(make_word(MODE_KEY, $urandom, v, $urandom_range(0, 4) == 0,
                            $urandom_range(0, 2) != 0));
      end else if (p < 42) send_word(make_word(MODE_DWRITE, pick_cmd(), $urandom, $urandom,
                                               $urandom));
      else if (p < 55) send_word(make_word(MODE_DREAD, $urandom, $urandom, $urandom,
                                           $urandom));
      else if (p < 60) ctrl(pick_ctrl());
      else if (p < 66) send_word(make_word(MODE_SREAD, $urandom, $urandom, $urandom,
                                           $urandom));
      else if (p < 98) tick_n(1);
      else send_word(make_word($urandom_range(6, 7), $urandom, $urandom, $urandom,
                               $urandom));
    end
  endtask

  initial begin
    model_reset();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_interval(16'd1);
    test_directed();
    wait_drained();
    write_interval(16'd0);
    test_full_queue();
    wait_drained();
    write_interval(16'd2);
    test_random(150);
    wait_drained();
    write_interval(16'd1);
    stall_mode = 0;
    test_random(150);
    stall_mode = 1;
    wait_drained();
    write_interval(16'd3);
    test_random(150);
    wait_drained();
    // largest interval: pump stays armed, ticks only count down
    write_interval(16'hffff);
    test_random(50);
    wait_drained();
    if (errors == 0) $display("tb_keyboard_usart_8251_interface OK");
    else $display("tb_keyboard_usart_8251_interface NOT OK");
    $finish;
  end

  initial begin
    #20ms;
    $display("tb_keyboard_usart_8251_interface NOT OK");
    $finish;
  end

endmodule
